// ===== design/scf_pkg.sv =====
// Shared types and constants for the sprite chain flush sequencer.
// No dependencies; the sequencer, cfg, ctrl and datapath files import this package.
package scf_pkg;

    // Layer geometry and video memory map
    localparam logic [4:0]  MAX_COLUMNS  = 5'd21;
    localparam logic [15:0] Y_ORIGIN     = 16'd496;
    localparam logic [15:0] SHRINK_BASE  = 16'd32768;
    localparam logic [15:0] YCTRL_BASE   = 16'd33280;
    localparam logic [15:0] XPOS_BASE    = 16'd33792;
    localparam logic [15:0] STICKY_WORD  = 16'h0040;

    // Position words carry pixels times 128; one column is 16 pixels wide
    localparam int POS_SHIFT    = 7;
    localparam int COLUMN_SHIFT = 4;

    // Configuration register map
    localparam int          CFG_ADDR_W        = 3;
    localparam logic        CFG_BASE_SPRITE   = 1'b0;
    localparam logic        CFG_COLUMN_HEIGHT = 1'b1;
    localparam logic [8:0]  BASE_SPRITE_RST   = 9'd0;
    localparam logic [5:0]  COLUMN_HEIGHT_RST = 6'd32;

    // Sequencer phases, one-hot
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SHRINK = 7'b0000010,
        ST_LAYOUT = 7'b0000100,
        ST_YDRV0  = 7'b0001000,
        ST_YDRV1  = 7'b0010000,
        ST_XDRV0  = 7'b0100000,
        ST_XDRV1  = 7'b1000000
    } scf_state_t;

    // Controller to datapath
    typedef struct packed {
        scf_state_t phase;
        logic       load;
        logic       emit;
        logic       slot_clr;
        logic       slot_inc;
        logic       last;
    } scf_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [3:0] mask;
        logic       wrap;
        logic       slot_end;
    } scf_status_t;

endpackage

// ===== design/scf_if.sv =====
// Handshake channels of the sprite chain flush sequencer.
// Request channel in, video memory write channel out; no dependencies.
interface scf_req_if;
    logic              valid;
    logic              ready;
    logic [3:0]        dirty_mask;
    logic [4:0]        columns;
    logic [4:0]        left_slot;
    logic signed [9:0] base_x;
    logic signed [9:0] y_pos;
    logic [11:0]       shrink_word;

    modport source (
        output valid, dirty_mask, columns, left_slot, base_x, y_pos, shrink_word,
        input  ready
    );
    modport sink (
        input  valid, dirty_mask, columns, left_slot, base_x, y_pos, shrink_word,
        output ready
    );
endinterface

interface scf_wr_if;
    logic        valid;
    logic        ready;
    logic [15:0] vram_addr;
    logic [15:0] vram_data;
    logic        last;

    modport source (
        output valid, vram_addr, vram_data, last,
        input  ready
    );
    modport sink (
        input  valid, vram_addr, vram_data, last,
        output ready
    );
endinterface

// ===== design/sprite_chain_flush_sequencer.sv =====
// After a request is accepted, its first write enters the output register when
// that has room. Throughput: one write per cycle while the sink keeps ready high;
// a request with N writes (N up to 2*MAX_COLUMNS+2) holds the request channel.
// The next request is taken once the final write sits in the output register.
// Reset: rst_n clears the sequencer to idle and the output to empty at once;
// base_sprite returns to 0 and column_height to 32. No clearing pass.
module sprite_chain_flush_sequencer
    import scf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    scf_req_if.sink               req,
    scf_wr_if.source              wr,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [8:0]  base_sprite;
    logic [5:0]  column_height;
    scf_cmd_t    cmd;
    scf_status_t sts;

    // Configuration registers
    scf_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .base_sprite   (base_sprite),
        .column_height (column_height)
    );

    // Phase sequencer
    scf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_mask   (req.dirty_mask),
        .in_ready  (req.ready),
        .out_ready (wr.ready),
        .out_valid (wr.valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Address and data generation
    scf_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .base_sprite   (base_sprite),
        .column_height (column_height),
        .dirty_mask    (req.dirty_mask),
        .columns       (req.columns),
        .left_slot     (req.left_slot),
        .base_x        (req.base_x),
        .y_pos         (req.y_pos),
        .shrink_word   (req.shrink_word),
        .vram_addr     (wr.vram_addr),
        .vram_data     (wr.vram_data),
        .last          (wr.last)
    );

endmodule

// ===== design/scf_cfg.sv =====
// APB-style configuration registers: base sprite index and column height.
// Depends on scf_pkg for the register map and reset values.
module scf_cfg
    import scf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output logic [8:0]            base_sprite,
    output logic [5:0]            column_height
);

    logic [8:0] base_sprite_reg;
    logic [5:0] column_height_reg;
    logic       wr_en;
    logic       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    // Write on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_sprite_reg   <= BASE_SPRITE_RST;
            column_height_reg <= COLUMN_HEIGHT_RST;
        end
        else if (wr_en)
        begin
            if (reg_sel == CFG_BASE_SPRITE)
            begin
                base_sprite_reg <= pwdata[8:0];
            end
            else
            begin
                column_height_reg <= pwdata[5:0];
            end
        end
    end

    // Read back
    always_comb
    begin
        if (reg_sel == CFG_BASE_SPRITE)
        begin
            prdata = {23'd0, base_sprite_reg};
        end
        else
        begin
            prdata = {26'd0, column_height_reg};
        end
    end

    assign base_sprite   = base_sprite_reg;
    assign column_height = column_height_reg;

endmodule

// ===== design/scf_ctrl.sv =====
// Phase sequencer: walks shrink, layout, driver Y and driver X phases.
// Depends on scf_pkg for the state, command and status types.
module scf_ctrl
    import scf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [3:0]  in_mask,
    output logic        in_ready,
    input  logic        out_ready,
    output logic        out_valid,
    input  scf_status_t sts,
    output scf_cmd_t    cmd
);

    scf_state_t state_reg;
    scf_state_t state_next;
    scf_state_t first_phase;
    scf_state_t follow;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       can_emit;
    logic       phase_done;

    // Pick the first phase of a fresh request
    always_comb
    begin
        priority if (in_mask[0])
        begin
            first_phase = ST_SHRINK;
        end
        else if (in_mask[1])
        begin
            first_phase = ST_LAYOUT;
        end
        else if (in_mask[2])
        begin
            first_phase = ST_YDRV0;
        end
        else if (in_mask[3])
        begin
            first_phase = ST_XDRV0;
        end
        else
        begin
            first_phase = ST_IDLE;
        end
    end

    // Phase that follows the current one
    always_comb
    begin
        unique case (state_reg)
            ST_SHRINK:
            begin
                priority if (sts.mask[1])
                begin
                    follow = ST_LAYOUT;
                end
                else if (sts.mask[2])
                begin
                    follow = ST_YDRV0;
                end
                else if (sts.mask[3])
                begin
                    follow = ST_XDRV0;
                end
                else
                begin
                    follow = ST_IDLE;
                end
            end
            ST_LAYOUT:
            begin
                follow = ST_XDRV0;
            end
            ST_YDRV0:
            begin
                priority if (sts.wrap)
                begin
                    follow = ST_YDRV1;
                end
                else if (sts.mask[3])
                begin
                    follow = ST_XDRV0;
                end
                else
                begin
                    follow = ST_IDLE;
                end
            end
            ST_YDRV1:
            begin
                follow = sts.mask[3] ? ST_XDRV0 : ST_IDLE;
            end
            ST_XDRV0:
            begin
                follow = sts.wrap ? ST_XDRV1 : ST_IDLE;
            end
            default:
            begin
                follow = ST_IDLE;
            end
        endcase
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign can_emit   = !out_valid_reg || out_ready;
    assign phase_done = !((state_reg == ST_SHRINK) || (state_reg == ST_LAYOUT))
                        || sts.slot_end;

    // Issue one write per cycle while the output register has room
    always_comb
    begin
        cmd            = '0;
        cmd.phase      = state_reg;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == ST_IDLE)
        begin
            if (in_valid)
            begin
                cmd.load   = 1'b1;
                state_next = first_phase;
            end
        end
        else if (can_emit)
        begin
            cmd.emit       = 1'b1;
            out_valid_next = 1'b1;
            if (phase_done)
            begin
                cmd.slot_clr = 1'b1;
                cmd.last     = (follow == ST_IDLE);
                state_next   = follow;
            end
            else
            begin
                cmd.slot_inc = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== design/scf_dp.sv =====
// Datapath: request capture, clamping, control word math and the output register.
// Depends on scf_pkg for constants and the command and status types.
module scf_dp
    import scf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  scf_cmd_t          cmd,
    output scf_status_t       sts,
    input  logic [8:0]        base_sprite,
    input  logic [5:0]        column_height,
    input  logic [3:0]        dirty_mask,
    input  logic [4:0]        columns,
    input  logic [4:0]        left_slot,
    input  logic signed [9:0] base_x,
    input  logic signed [9:0] y_pos,
    input  logic [11:0]       shrink_word,
    output logic [15:0]       vram_addr,
    output logic [15:0]       vram_data,
    output logic              last
);

    logic [3:0]  mask_reg;
    logic [4:0]  cols_reg;
    logic [4:0]  left_reg;
    logic [4:0]  slot_reg;
    logic [15:0] yword_reg;
    logic [15:0] xword0_reg;
    logic [15:0] xword1_reg;
    logic [11:0] shrink_reg;
    logic [15:0] addr_reg;
    logic [15:0] data_reg;
    logic        last_reg;

    logic [4:0]  cols_nz;
    logic [4:0]  cols_sat;
    logic [4:0]  left_clamp;
    logic [15:0] y_ext;
    logic [15:0] x_ext;
    logic [15:0] y_diff;
    logic [15:0] x_wrap;
    logic [4:0]  span;
    logic [15:0] base_ext;
    logic [15:0] slot_ext;
    logic [15:0] left_ext;
    logic        driver;
    logic [15:0] addr_next;
    logic [15:0] data_next;

    // Clamp the ring geometry
    assign cols_nz    = (columns == 5'd0) ? 5'd1 : columns;
    assign cols_sat   = (cols_nz > MAX_COLUMNS) ? MAX_COLUMNS : cols_nz;
    assign left_clamp = (left_slot >= cols_sat) ? (cols_sat - 5'd1) : left_slot;

    // Control words, all modulo 2^16
    assign y_ext  = {{6{y_pos[9]}}, y_pos};
    assign x_ext  = {{6{base_x[9]}}, base_x};
    assign y_diff = Y_ORIGIN - y_ext;
    assign span   = cols_sat - left_clamp;
    assign x_wrap = x_ext + {7'd0, span, 4'd0};

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mask_reg   <= dirty_mask;
            cols_reg   <= cols_sat;
            left_reg   <= left_clamp;
            shrink_reg <= shrink_word;
            yword_reg  <= {y_diff[15-POS_SHIFT:0], {POS_SHIFT{1'b0}}} + {10'd0, column_height};
            xword0_reg <= {x_ext[15-POS_SHIFT:0], {POS_SHIFT{1'b0}}};
            xword1_reg <= {x_wrap[15-POS_SHIFT:0], {POS_SHIFT{1'b0}}};
        end
    end

    // Slot counter for the per-column phases
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= 5'd0;
        end
        else if (cmd.load || cmd.slot_clr)
        begin
            slot_reg <= 5'd0;
        end
        else if (cmd.slot_inc)
        begin
            slot_reg <= slot_reg + 5'd1;
        end
    end

    assign sts.mask     = mask_reg;
    assign sts.wrap     = (left_reg != 5'd0);
    assign sts.slot_end = (slot_reg == (cols_reg - 5'd1));

    assign base_ext = {7'd0, base_sprite};
    assign slot_ext = {11'd0, slot_reg};
    assign left_ext = {11'd0, left_reg};
    assign driver   = (slot_reg == left_reg) || (sts.wrap && (slot_reg == 5'd0));

    // Select the write for the current phase
    always_comb
    begin
        unique case (cmd.phase)
            ST_SHRINK:
            begin
                addr_next = SHRINK_BASE + base_ext + slot_ext;
                data_next = {4'd0, shrink_reg};
            end
            ST_LAYOUT:
            begin
                addr_next = YCTRL_BASE + base_ext + slot_ext;
                data_next = driver ? yword_reg : STICKY_WORD;
            end
            ST_YDRV0:
            begin
                addr_next = YCTRL_BASE + base_ext + left_ext;
                data_next = yword_reg;
            end
            ST_YDRV1:
            begin
                addr_next = YCTRL_BASE + base_ext;
                data_next = yword_reg;
            end
            ST_XDRV0:
            begin
                addr_next = XPOS_BASE + base_ext + left_ext;
                data_next = xword0_reg;
            end
            ST_XDRV1:
            begin
                addr_next = XPOS_BASE + base_ext;
                data_next = xword1_reg;
            end
            default:
            begin
                addr_next = '0;
                data_next = '0;
            end
        endcase
    end

    // Output register, loaded once per issued write
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            addr_reg <= addr_next;
            data_reg <= data_next;
            last_reg <= cmd.last;
        end
    end

    assign vram_addr = addr_reg;
    assign vram_data = data_reg;
    assign last      = last_reg;

endmodule

// ===== design/scf_checker.sv =====
// Port-level checks for the sprite chain flush sequencer, bound to the top level.
// Depends only on the top level's ports.
module scf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [3:0]  in_mask,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_address,
    input logic [15:0] out_data,
    input logic        out_last
);

    // Hold a stalled write
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_address)
            && $stable(out_data) && $stable(out_last))
        else $error("stalled write changed");

    // Drop an empty request without any write
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_mask == 4'd0) && !out_valid |=> !out_valid)
        else $error("empty request produced a write");

    // Block new requests while one is being sequenced
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_mask != 4'd0) |=> !in_ready)
        else $error("request accepted during sequencing");

    // Nothing follows a final write taken while the sequencer is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last && in_ready |=> !out_valid)
        else $error("write issued right after final write");

endmodule

bind sprite_chain_flush_sequencer scf_checker u_scf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .in_mask     (req.dirty_mask),
    .out_valid   (wr.valid),
    .out_ready   (wr.ready),
    .out_address (wr.vram_addr),
    .out_data    (wr.vram_data),
    .out_last    (wr.last)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench for sprite_chain_flush_sequencer: flush requests in, video memory writes out.
// Predicts each write sequence locally and checks it; needs scf_pkg and scf_if.
module tb;
    import scf_pkg::*;

    // Dirty mask bits of a flush request
    localparam logic [3:0] DIRTY_SHRINK = 4'b0001;
    localparam logic [3:0] DIRTY_LAYOUT = 4'b0010;
    localparam logic [3:0] DIRTY_YPOS   = 4'b0100;
    localparam logic [3:0] DIRTY_XPOS   = 4'b1000;

    // Register byte addresses
    localparam logic [CFG_ADDR_W-1:0] ADDR_BASE_SPRITE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] ADDR_COLUMN_HEIGHT = 3'd4;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_FLUSHES = 50;

    typedef struct packed {
        logic [3:0]        mask;
        logic [4:0]        columns;
        logic [4:0]        leftmost;
        logic signed [9:0] base_x;
        logic signed [9:0] y_pos;
        logic [11:0]       shrink;
    } flush_req_t;

    typedef struct packed {
        logic [15:0] addr;
        logic [15:0] data;
        logic        last;
    } vram_wr_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    scf_req_if req_ch ();
    scf_wr_if  wr_ch ();

    sprite_chain_flush_sequencer DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .wr      (wr_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the layer registers
    logic [8:0] cfg_base_sprite;
    logic [5:0] cfg_column_height;

    vram_wr_t pending_writes[$];
    int       mismatch_count;
    int       cycle_count;

    // Sender pacing and receiver stall pattern
    bit pace_gaps;
    int burst_left;
    int stall_pct;
    int max_stall;
    int stall_run;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d writes outstanding",
                     cycle_count, pending_writes.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random stall runs of random length
    always @(negedge clk)
    begin
        if (stall_run > 0)
        begin
            stall_run--;
            wr_ch.ready = 1'b0;
        end
        else if (stall_pct != 0 && $urandom_range(99) < stall_pct)
        begin
            stall_run = $urandom_range(max_stall - 1);
            wr_ch.ready = 1'b0;
        end
        else
        begin
            wr_ch.ready = 1'b1;
        end
    end

    function automatic void note_mismatch(string msg);
        if (mismatch_count < 10)
            $display("%0t: %s", $realtime, msg);
        mismatch_count++;
    endfunction

    // Compare each accepted write against the oldest prediction
    always @(posedge clk)
    begin : check_writes
        vram_wr_t exp_w;
        if (rst_n && wr_ch.valid && wr_ch.ready)
        begin
            if (pending_writes.size() == 0)
            begin
                note_mismatch($sformatf("unexpected write addr %h data %h last %b",
                              wr_ch.vram_addr, wr_ch.vram_data, wr_ch.last));
            end
            else
            begin
                exp_w = pending_writes.pop_front();
                if (wr_ch.vram_addr !== exp_w.addr || wr_ch.vram_data !== exp_w.data
                    || wr_ch.last !== exp_w.last)
                    note_mismatch($sformatf(
                        "expected addr %h data %h last %b, got addr %h data %h last %b",
                        exp_w.addr, exp_w.data, exp_w.last,
                        wr_ch.vram_addr, wr_ch.vram_data, wr_ch.last));
            end
        end
    end

    function automatic void add_write(logic [15:0] addr, logic [15:0] data);
        vram_wr_t w;
        w.addr = addr;
        w.data = data;
        w.last = 1'b0;
        pending_writes.push_back(w);
    endfunction

    // Driver X words: leftmost slot, then slot 0 shifted right when the ring wraps
    function automatic void add_driver_x(logic [4:0] cols, logic [4:0] left,
                                         logic [15:0] base, logic [15:0] x16);
        logic [15:0] x_wrap;
        add_write(XPOS_BASE + base + {11'b0, left}, x16 << POS_SHIFT);
        if (left != 0)
        begin
            x_wrap = x16 + ({11'b0, 5'(cols - left)} << COLUMN_SHIFT);
            add_write(XPOS_BASE + base, x_wrap << POS_SHIFT);
        end
    endfunction

    // Append the write sequence that one flush request produces
    function automatic void predict_flush_writes(flush_req_t r);
        logic [4:0]  cols;
        logic [4:0]  left;
        logic [15:0] base;
        logic [15:0] x16;
        logic [15:0] y16;
        logic [15:0] yword;
        int          first;
        vram_wr_t    w;
        first = pending_writes.size();
        cols = (r.columns == 0) ? 5'd1 : r.columns;
        if (cols > MAX_COLUMNS)
            cols = MAX_COLUMNS;
        left = (r.leftmost >= cols) ? 5'(cols - 1) : r.leftmost;
        base = {7'b0, cfg_base_sprite};
        x16 = {{6{r.base_x[9]}}, r.base_x};
        y16 = {{6{r.y_pos[9]}}, r.y_pos};
        yword = ((Y_ORIGIN - y16) << POS_SHIFT) + {10'b0, cfg_column_height};

        if (r.mask & DIRTY_SHRINK)
            for (int s = 0; s < cols; s++)
                add_write(SHRINK_BASE + base + 16'(s), {4'b0, r.shrink});

        if (r.mask & DIRTY_LAYOUT)
        begin
            // Drivers get the Y word, every other slot sticks to its left neighbor
            for (int s = 0; s < cols; s++)
                add_write(YCTRL_BASE + base + 16'(s),
                          (s == left || (left != 0 && s == 0)) ? yword : STICKY_WORD);
            add_driver_x(cols, left, base, x16);
        end
        else
        begin
            if (r.mask & DIRTY_YPOS)
            begin
                add_write(YCTRL_BASE + base + {11'b0, left}, yword);
                if (left != 0)
                    add_write(YCTRL_BASE + base, yword);
            end
            if (r.mask & DIRTY_XPOS)
                add_driver_x(cols, left, base, x16);
        end

        // Flag the final write of this request
        if (pending_writes.size() > first)
        begin
            w = pending_writes.pop_back();
            w.last = 1'b1;
            pending_writes.push_back(w);
        end
    endfunction

    function automatic flush_req_t build_request(logic [3:0] mask, logic [4:0] cols,
                                                 logic [4:0] left, logic signed [9:0] x,
                                                 logic signed [9:0] y, logic [11:0] sh);
        flush_req_t r;
        r.mask     = mask;
        r.columns  = cols;
        r.leftmost = left;
        r.base_x   = x;
        r.y_pos    = y;
        r.shrink   = sh;
        return r;
    endfunction

    // Mostly legal geometry, with occasional out-of-range columns and slots
    function automatic flush_req_t random_request();
        flush_req_t r;
        int         span;
        r.mask    = ($urandom_range(19) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
        r.columns = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(1, MAX_COLUMNS));
        span = (r.columns == 0) ? 1 : ((r.columns > MAX_COLUMNS) ? MAX_COLUMNS : r.columns);
        r.leftmost = ($urandom_range(9) < 3) ? 5'($urandom) : 5'($urandom_range(span - 1));
        r.base_x   = 10'($urandom);
        r.y_pos    = 10'($urandom);
        r.shrink   = 12'($urandom);
        return r;
    endfunction

    // Present one item at the falling edge and hold it until accepted; valid stays high
    task automatic send_flush(flush_req_t r);
        req_ch.valid         = 1'b1;
        req_ch.dirty_mask    = r.mask;
        req_ch.columns       = r.columns;
        req_ch.left_slot     = r.leftmost;
        req_ch.base_x        = r.base_x;
        req_ch.y_pos         = r.y_pos;
        req_ch.shrink_word   = r.shrink;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predict_flush_writes(r);
        @(negedge clk);
    endtask

    // Send in bursts with idle gaps between them when pacing is on
    task automatic send_paced(flush_req_t r);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 10);
            if (pace_gaps)
            begin
                req_ch.valid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
        burst_left--;
        send_flush(r);
    endtask

    // Drop valid, wait for every predicted write, then let the pipeline settle
    task automatic drain_writes();
        req_ch.valid = 1'b0;
        while (pending_writes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write a register and read it back
    task automatic write_register(logic [CFG_ADDR_W-1:0] addr, logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == ADDR_BASE_SPRITE)
            cfg_base_sprite = value[8:0];
        else
            cfg_column_height = value[5:0];
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== value)
            note_mismatch($sformatf("register %0d read %h, expected %h", addr, prdata, value));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Every mask value, field extremes, and the clamping cases
    task automatic test_directed_flushes();
        pace_gaps = 1'b0;
        stall_pct = 25;
        max_stall = 4;
        for (int m = 1; m < 16; m++)
            send_flush(build_request(4'(m), 5'(m + 3), 5'(m % 5),
                                     m[0] ? -10'sd512 : 10'sd511,
                                     m[1] ? 10'sd511 : -10'sd512,
                                     m[2] ? 12'hFFF : 12'h000));
        // Empty mask, then zero columns
        send_flush(build_request(4'd0, 5'd9, 5'd3, 10'sd100, -10'sd7, 12'h5A5));
        send_flush(build_request(DIRTY_LAYOUT, 5'd0, 5'd0, -10'sd1, 10'sd0, 12'h000));
        // Columns saturate, leftmost clamps
        send_flush(build_request(4'hF, 5'd31, 5'd31, 10'sd511, -10'sd512, 12'hFFF));
        send_flush(build_request(DIRTY_LAYOUT | DIRTY_XPOS, 5'd21, 5'd20,
                                 -10'sd300, 10'sd200, 12'h123));
        send_flush(build_request(DIRTY_YPOS | DIRTY_XPOS, 5'd22, 5'd25,
                                 10'sd17, 10'sd496, 12'hABC));
        send_flush(build_request(DIRTY_YPOS, 5'd7, 5'd7, 10'sd0, -10'sd100, 12'h000));
        // Single column, no wrap
        send_flush(build_request(DIRTY_XPOS | DIRTY_SHRINK, 5'd1, 5'd0,
                                 10'sd255, 10'sd0, 12'h800));
        drain_writes();
    endtask

    // Several register settings, the extremes of each field among them
    task automatic test_register_settings();
        logic [8:0] bases   [6] = '{9'd380, 9'd511, 9'd1, 9'd341, 9'd170, 9'd0};
        logic [5:0] heights [6] = '{6'd1, 6'd63, 6'd0, 6'd42, 6'd21, 6'd32};
        pace_gaps = 1'b1;
        for (int k = 0; k < 6; k++)
        begin
            write_register(ADDR_BASE_SPRITE, {23'b0, bases[k]});
            write_register(ADDR_COLUMN_HEIGHT, {26'b0, heights[k]});
            stall_pct = 10 * k;
            max_stall = 2 + k;
            for (int i = 0; i < 6; i++)
                send_paced(random_request());
            drain_writes();
        end
    endtask

    // Long random run with changing pacing and stalls, and one full drain midway
    task automatic test_random_flushes();
        flush_req_t r;
        int         sent;
        sent = 0;
        while (sent < RANDOM_FLUSHES)
        begin
            if (sent % 25 == 0)
            begin
                pace_gaps = ($urandom_range(2) != 0);
                stall_pct = $urandom_range(3) * 15;
                max_stall = $urandom_range(1, 12);
            end
            if (sent == RANDOM_FLUSHES / 2)
                drain_writes();
            r = random_request();
            send_paced(r);
            if (r.mask != 0)
                sent++;
        end
        drain_writes();
    endtask

    initial
    begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        req_ch.valid        = 1'b0;
        req_ch.dirty_mask   = '0;
        req_ch.columns      = '0;
        req_ch.left_slot    = '0;
        req_ch.base_x       = '0;
        req_ch.y_pos        = '0;
        req_ch.shrink_word  = '0;
        wr_ch.ready         = 1'b0;
        cfg_base_sprite     = BASE_SPRITE_RST;
        cfg_column_height   = COLUMN_HEIGHT_RST;
        mismatch_count      = 0;
        cycle_count         = 0;
        pace_gaps           = 1'b0;
        burst_left          = 0;
        stall_pct           = 0;
        max_stall           = 1;
        stall_run           = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_flushes();
        test_register_settings();
        test_random_flushes();

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
